[src/pip_pkg.sv]
// Shared constants, request codes and control types of the point-in-polygon block.
// No dependencies; compiled first.
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 16;

  // a polygon needs this many vertices before a query can answer inside
  localparam int MIN_POLY_VERTICES = 3;

  // register stages between the evaluator's input and its parity flop
  localparam int EVAL_LAT = 2;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef struct packed {
    logic start;  // clear parity for a new query
    logic valid;  // an edge is presented this cycle
  } eval_ctl_t;

endpackage

[src/pip_if.sv]
// Valid/ready channel interfaces for request items and result items.
// Depends on pip_pkg for default widths.
interface pip_req_if #(
  parameter int CW = pip_pkg::COORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic signed [CW-1:0] coord_x;
  logic signed [CW-1:0] coord_y;

  modport source (output valid, req_type, coord_x, coord_y, input ready);
  modport sink (input valid, req_type, coord_x, coord_y, output ready);
endinterface

interface pip_res_if #(
  parameter int CNT_W = $clog2(pip_pkg::MAX_VERTICES_DEF + 1)
);
  logic             valid;
  logic             ready;
  logic             inside_res;
  logic [CNT_W-1:0] vertex_count;
  logic             store_full;

  modport source (output valid, inside_res, vertex_count, store_full, input ready);
  modport sink (input valid, inside_res, vertex_count, store_full, output ready);
endinterface

[src/point_in_polygon_test_top.sv]
// Point-in-polygon test, even-odd crossing rule. Clear and append items
// finish at acceptance; their result is registered once the output register
// is free. A query with at least three stored vertices rotates the whole ring
// (MAX_VERTICES cells) past one pipelined edge evaluator, one vertex per
// cycle, then drains the evaluator pipeline before its result is formed;
// the walk covers the full ring, whatever the stored count. One item is
// in work at a time; the next is taken once the current result has entered
// the output register, even while it still waits there to be taken.
// Depends on pip_pkg, pip_if, pip_vtx_cell and pip_edge_eval.
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pip_req_if.sink  req_i,
  pip_res_if.source res_o
);
  import pip_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int DRN_W = $clog2(EVAL_LAT + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [DRN_W-1:0]     drn_q, drn_d;
  logic signed [CW-1:0] px_q, px_d, py_q, py_d;
  logic signed [CW-1:0] last_x_q, last_y_q, prev_x_q, prev_y_q;
  logic                 pend_in_q, pend_in_d, pend_full_q, pend_full_d;
  logic                 res_vld_q, res_vld_d;
  logic                 res_in_q, res_full_q;
  logic [CNT_W-1:0]     res_cnt_q;

  logic                 req_fire, out_free, app_wr, walk;
  logic                 fin, fin_in, fin_full;
  logic                 eval_in;
  eval_ctl_t            ctl;
  logic signed [CW-1:0] bx, by;

  logic signed [CW-1:0] cell_x [MAX_VERTICES];
  logic signed [CW-1:0] cell_y [MAX_VERTICES];

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !res_vld_q || res_o.ready;
  assign walk        = (state_q == ST_WALK);
  assign app_wr      = req_fire && (req_e'(req_i.req_type) == REQ_APPEND)
                       && (cnt_q < CNT_W'(MAX_VERTICES));

  // vertex ring: cell k takes cell k+1 while rotating; cell 0 is the head
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
    pip_vtx_cell #(.CW(CW)) u_cell (
      .clk_i    (clk_i),
      .load_i   (app_wr && (cnt_q[IDX_W-1:0] == IDX_W'(k))),
      .shift_i  (walk),
      .load_x_i (req_i.coord_x),
      .load_y_i (req_i.coord_y),
      .nbr_x_i  (cell_x[(k + 1) % MAX_VERTICES]),
      .nbr_y_i  (cell_y[(k + 1) % MAX_VERTICES]),
      .x_o      (cell_x[k]),
      .y_o      (cell_y[k])
    );
  end

  // first vertex pairs with the last one
  assign bx = (idx_q == '0) ? last_x_q : prev_x_q;
  assign by = (idx_q == '0) ? last_y_q : prev_y_q;

  always_comb begin
    ctl.start = req_fire && (req_e'(req_i.req_type) == REQ_QUERY);
    ctl.valid = walk && (CNT_W'(idx_q) < cnt_q);
  end

  pip_edge_eval #(.CW(CW)) u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .px_i     (px_q),
    .py_i     (py_q),
    .ax_i     (cell_x[0]),
    .ay_i     (cell_y[0]),
    .bx_i     (bx),
    .by_i     (by),
    .inside_o (eval_in)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    drn_d       = drn_q;
    px_d        = px_q;
    py_d        = py_q;
    pend_in_d   = pend_in_q;
    pend_full_d = pend_full_q;
    fin         = 1'b0;
    fin_in      = 1'b0;
    fin_full    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_e'(req_i.req_type))
            REQ_CLEAR: begin
              cnt_d = '0;
              fin   = 1'b1;
            end
            REQ_APPEND: begin
              fin = 1'b1;
              if (app_wr) begin
                cnt_d = cnt_q + CNT_W'(1);
              end else begin
                fin_full = 1'b1;
              end
            end
            REQ_QUERY: begin
              if (cnt_q < CNT_W'(MIN_POLY_VERTICES)) begin
                fin = 1'b1;
              end else begin
                px_d    = req_i.coord_x;
                py_d    = req_i.coord_y;
                idx_d   = '0;
                state_d = ST_WALK;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(MAX_VERTICES - 1)) begin
          drn_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drn_d = drn_q + DRN_W'(1);
        if (drn_q == DRN_W'(EVAL_LAT)) begin
          fin    = 1'b1;
          fin_in = eval_in;
        end
      end
      ST_WAIT: begin
        fin      = 1'b1;
        fin_in   = pend_in_q;
        fin_full = pend_full_q;
      end
      default: state_d = ST_IDLE;
    endcase

    if (fin) begin
      if (out_free) begin
        state_d = ST_IDLE;
      end else begin
        pend_in_d   = fin_in;
        pend_full_d = fin_full;
        state_d     = ST_WAIT;
      end
    end

    res_vld_d = res_vld_q && !res_o.ready;
    if (fin && out_free) begin
      res_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      drn_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      drn_q     <= drn_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q        <= px_d;
    py_q        <= py_d;
    pend_in_q   <= pend_in_d;
    pend_full_q <= pend_full_d;
    if (app_wr) begin
      last_x_q <= req_i.coord_x;
      last_y_q <= req_i.coord_y;
    end
    if (walk) begin
      prev_x_q <= cell_x[0];
      prev_y_q <= cell_y[0];
    end
    if (fin && out_free) begin
      res_in_q   <= fin_in;
      res_full_q <= fin_full;
      res_cnt_q  <= cnt_d;
    end
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.inside_res   = res_in_q;
  assign res_o.vertex_count = res_cnt_q;
  assign res_o.store_full   = res_full_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above store depth");
  a_append_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    app_wr |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("append did not advance vertex count");
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk && (idx_q == IDX_W'(MAX_VERTICES - 1))) |=> (state_q == ST_DRAIN))
    else $error("ring walk did not end after a full rotation");
  a_cnt_stable_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk || state_q == ST_DRAIN) |-> $stable(cnt_q))
    else $error("vertex count changed during a query");
`endif

endmodule

[src/pip_vtx_cell.sv]
// One vertex cell of the storage ring: holds x/y, loads on append,
// takes its neighbor's vertex while the ring rotates. No package use.
module pip_vtx_cell #(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic                 shift_i,
  input  logic signed [CW-1:0] load_x_i,
  input  logic signed [CW-1:0] load_y_i,
  input  logic signed [CW-1:0] nbr_x_i,
  input  logic signed [CW-1:0] nbr_y_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o
);

  logic signed [CW-1:0] x_q, x_d;
  logic signed [CW-1:0] y_q, y_d;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (load_i) begin
      x_d = load_x_i;
      y_d = load_y_i;
    end else if (shift_i) begin
      x_d = nbr_x_i;
      y_d = nbr_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

[src/pip_edge_eval.sv]
// Pipelined edge test: straddle check, exact cross-multiplied crossing test,
// even-odd parity. Depends on pip_pkg (eval_ctl_t).
module pip_edge_eval #(
  parameter int CW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pip_pkg::eval_ctl_t    ctl_i,
  input  logic signed [CW-1:0]  px_i,
  input  logic signed [CW-1:0]  py_i,
  input  logic signed [CW-1:0]  ax_i,
  input  logic signed [CW-1:0]  ay_i,
  input  logic signed [CW-1:0]  bx_i,
  input  logic signed [CW-1:0]  by_i,
  output logic                  inside_o
);
  import pip_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  // stage 1: differences
  logic                 s1_vld_q, s1_vld_d;
  logic                 s1_strad_q;
  logic signed [DW-1:0] s1_dpx_q, s1_d_q, s1_dbx_q, s1_dpy_q;
  // stage 2: products
  logic                 s2_vld_q, s2_vld_d;
  logic                 s2_dpos_q;
  logic signed [PW-1:0] s2_lhs_q, s2_rhs_q;
  logic                 par_q, par_d;

  logic                 strad;
  logic                 hit;

  assign strad = (ay_i > py_i) != (by_i > py_i);

  always_comb begin
    s1_vld_d = ctl_i.valid && strad;
    s2_vld_d = s1_vld_q && s1_strad_q;
    // d is never zero on a straddling edge
    hit = s2_dpos_q ? (s2_lhs_q < s2_rhs_q) : (s2_rhs_q < s2_lhs_q);
    par_d = par_q;
    if (ctl_i.start) begin
      par_d = 1'b0;
    end else if (s2_vld_q && hit) begin
      par_d = !par_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_strad_q <= strad;
    s1_dpx_q   <= DW'(px_i) - DW'(ax_i);
    s1_d_q     <= DW'(by_i) - DW'(ay_i);
    s1_dbx_q   <= DW'(bx_i) - DW'(ax_i);
    s1_dpy_q   <= DW'(py_i) - DW'(ay_i);
    s2_dpos_q  <= !s1_d_q[DW-1] && (s1_d_q != '0);
    s2_lhs_q   <= PW'(s1_dpx_q) * PW'(s1_d_q);
    s2_rhs_q   <= PW'(s1_dbx_q) * PW'(s1_dpy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      par_q    <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      par_q    <= par_d;
    end
  end

  assign inside_o = par_q;

`ifndef ASSERT_OFF
  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> $past(s1_vld_q))
    else $error("stage 2 valid without stage 1 item");
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> !par_q)
    else $error("parity not cleared at query start");
  a_par_toggle_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (par_q != $past(par_q)) |-> ($past(s2_vld_q) || $past(ctl_i.start)))
    else $error("parity changed without an edge hit");
`endif

endmodule
